// ===== rtl/core/mcu_instruction_execute_subset_defines.svh =====
// Assertion macros shared by the checker.
// No dependencies.
`ifndef MCU_INSTRUCTION_EXECUTE_SUBSET_DEFINES_SVH
`define MCU_INSTRUCTION_EXECUTE_SUBSET_DEFINES_SVH
// implication checked every clock outside reset
`define MIES_ASSERT_IMP(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("mies check failed");
// next-cycle implication
`define MIES_ASSERT_NXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("mies check failed");
`endif

// ===== rtl/core/mies_pkg.sv =====
// Package: constants, opcode masks and payload types of the execute unit.
// No dependencies.
package mies_pkg;
    localparam int PcWidth = 16;
    localparam logic [15:0] StackTop = 16'd2303;

    localparam logic [1:0] WK_NONE  = 2'd0;
    localparam logic [1:0] WK_IO    = 2'd1;
    localparam logic [1:0] WK_STACK = 2'd2;

    localparam logic [15:0] MASK_RR   = 16'hFC00;
    localparam logic [15:0] MASK_BYTE = 16'hFF00;
    localparam logic [15:0] MASK_NIB  = 16'hF000;
    localparam logic [15:0] MASK_ONE  = 16'hFE0F;
    localparam logic [15:0] MASK_SREG = 16'hFF8F;
    localparam logic [15:0] MASK_BIT  = 16'hFE08;
    localparam logic [15:0] MASK_CALL = 16'hFE0E;
    localparam logic [7:0]  KEEP_IT   = 8'hC0;
    localparam logic [7:0]  KEEP_LOG  = 8'hE1;
    localparam logic [7:0]  KEEP_ITH  = 8'hE0;

    typedef enum logic [4:0] {
        OP_NOP, OP_ADC, OP_ADD, OP_AND, OP_EOR, OP_CP, OP_CPC, OP_BRB,
        OP_ADIW, OP_CBI, OP_ANDI, OP_ASR, OP_COM, OP_BCLR, OP_BSET,
        OP_BLD, OP_BST, OP_CALL
    } t_op;

    typedef struct packed {
        logic [15:0] instruction_word;
        logic [15:0] second_word;
    } t_in;

    typedef struct packed {
        logic [15:0] next_pc;
        logic [7:0]  flags;
        logic [1:0]  write_kind;
        logic [15:0] write_address;
        logic [7:0]  write_data;
        logic        last;
    } t_out;

    function automatic t_op decode(input logic [15:0] w);
        t_op op;
        op = OP_NOP;
        unique case (w & MASK_RR)
            16'h1C00: op = OP_ADC;
            16'h0C00: op = OP_ADD;
            16'h2000: op = OP_AND;
            16'h2400: op = OP_EOR;
            16'h1400: op = OP_CP;
            16'h0400: op = OP_CPC;
            16'hF000, 16'hF400: op = OP_BRB;
            default: begin
                if ((w & MASK_BYTE) == 16'h9600) op = OP_ADIW;
                else if ((w & MASK_BYTE) == 16'h9800) op = OP_CBI;
                else if ((w & MASK_NIB) == 16'h7000) op = OP_ANDI;
                else if ((w & MASK_ONE) == 16'h9405) op = OP_ASR;
                else if ((w & MASK_ONE) == 16'h9400) op = OP_COM;
                else if ((w & MASK_SREG) == 16'h9488) op = OP_BCLR;
                else if ((w & MASK_SREG) == 16'h9408) op = OP_BSET;
                else if ((w & MASK_BIT) == 16'hF800) op = OP_BLD;
                else if ((w & MASK_BIT) == 16'hFA00) op = OP_BST;
                else if ((w & MASK_CALL) == 16'h940E) op = OP_CALL;
            end
        endcase
        return op;
    endfunction
endpackage

// ===== rtl/core/mies_stream_if.sv =====
// Valid/ready channel interface.
// No dependencies; the payload type is a parameter.
interface mies_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/mies_regfile.sv =====
// Register file memory: 32 bytes, two registered read ports, two write ports,
// valid bits give zero after reset. Depends on mies_pkg.
module mies_regfile (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_re,
    input  logic [4:0] i_ra,
    input  logic [4:0] i_rb,
    output logic [7:0] o_da,
    output logic [7:0] o_db,
    input  logic       i_we0,
    input  logic [4:0] i_wa0,
    input  logic [7:0] i_wd0,
    input  logic       i_we1,
    input  logic [4:0] i_wa1,
    input  logic [7:0] i_wd1
);
    import mies_pkg::*;
    logic [7:0]  r_mem [32];
    logic [31:0] r_vld;
    logic [7:0]  r_qa, r_qb;
    logic        r_va, r_vb;

    // read data is held while i_re is low
    always_ff @(posedge i_clk) begin
        if (i_we0) r_mem[i_wa0] <= i_wd0;
        if (i_we1) r_mem[i_wa1] <= i_wd1;
        if (i_re) begin
            r_qa <= r_mem[i_ra];
            r_qb <= r_mem[i_rb];
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_va  <= 1'b0;
            r_vb  <= 1'b0;
        end else begin
            if (i_we0) r_vld[i_wa0] <= 1'b1;
            if (i_we1) r_vld[i_wa1] <= 1'b1;
            if (i_re) begin
                r_va <= r_vld[i_ra];
                r_vb <= r_vld[i_rb];
            end
        end
    end
    assign o_da = r_va ? r_qa : 8'h00;
    assign o_db = r_vb ? r_qb : 8'h00;
endmodule

// ===== rtl/core/mies_exec.sv =====
// Execute datapath: ALU, flags, branch and write generation for one instruction.
// Depends on mies_pkg.
module mies_exec (
    input  mies_pkg::t_op    i_op,
    input  logic [15:0]      i_w,
    input  logic [15:0]      i_w2,
    input  logic [7:0]       i_d,
    input  logic [7:0]       i_r,
    input  logic [7:0]       i_io,
    input  logic [7:0]       i_sreg,
    input  logic [15:0]      i_pc,
    input  logic [15:0]      i_sp,
    output logic [7:0]       o_sreg,
    output logic [15:0]      o_pc,
    output logic [15:0]      o_sp,
    output logic             o_rf_we,
    output logic [4:0]       o_rf_wa,
    output logic [7:0]       o_rf_wd,
    output logic             o_rf_we1,
    output logic [4:0]       o_rf_wa1,
    output logic [7:0]       o_rf_wd1,
    output logic             o_io_we,
    output logic [7:0]       o_io_wd,
    output mies_pkg::t_out   o_r0,
    output mies_pkg::t_out   o_r1,
    output logic             o_two
);
    import mies_pkg::*;
    logic [4:0]  rd, lo;
    logic [2:0]  b;
    logic [8:0]  sum9;
    logic [7:0]  res, hc, f, k8;
    logic [15:0] nxt, ret, sp1, word, wsum, off;
    logic        c;

    function automatic logic [7:0] nzs(input logic [7:0] fi, input logic [7:0] v);
        logic [7:0] fo;
        fo = fi;
        fo[2] = v[7];
        fo[1] = (v == 8'h00);
        fo[4] = v[7] ^ fi[3];
        return fo;
    endfunction

    always_comb begin
        rd   = i_w[8:4];
        b    = i_w[2:0];
        lo   = {2'b11, i_w[5:4], 1'b0};
        c    = i_sreg[0];
        nxt  = i_pc + 16'd1;
        ret  = i_pc + 16'd2;
        sp1  = i_sp - 16'd1;
        off  = {{9{i_w[9]}}, i_w[9:3]};
        word = {i_r, i_d};
        wsum = word + {10'd0, i_w[7:6], i_w[3:0]};
        k8   = {i_w[11:8], i_w[3:0]};
        o_sreg = i_sreg; o_pc = nxt; o_sp = i_sp;
        o_rf_we = 1'b0; o_rf_wa = rd; o_rf_wd = 8'h00;
        o_rf_we1 = 1'b0; o_rf_wa1 = lo + 5'd1; o_rf_wd1 = 8'h00;
        o_io_we = 1'b0; o_io_wd = i_io & ~(8'h01 << b);
        o_two = 1'b0;
        res = 8'h00; hc = 8'h00; f = 8'h00; sum9 = 9'd0;
        unique case (i_op)
            OP_ADC, OP_ADD: begin
                sum9 = {1'b0, i_d} + {1'b0, i_r} + {8'd0, (i_op == OP_ADC) & c};
                res = sum9[7:0];
                hc = (i_d & i_r) | (i_r & ~res) | (~res & i_d);
                f = i_sreg & KEEP_IT;
                f[5] = hc[3]; f[0] = hc[7];
                f[3] = (i_d[7] & i_r[7] & ~res[7]) | (~i_d[7] & ~i_r[7] & res[7]);
                o_sreg = nzs(f, res);
                o_rf_we = 1'b1; o_rf_wd = res;
            end
            OP_AND, OP_EOR: begin
                res = (i_op == OP_AND) ? (i_d & i_r) : (i_d ^ i_r);
                o_sreg = nzs(i_sreg & KEEP_LOG, res);
                o_rf_we = 1'b1; o_rf_wd = res;
            end
            OP_ANDI: begin
                res = i_d & k8;
                o_sreg = nzs(i_sreg & KEEP_LOG, res);
                o_rf_we = 1'b1; o_rf_wa = {1'b1, i_w[7:4]}; o_rf_wd = res;
            end
            OP_CP, OP_CPC: begin
                res = i_d - i_r - {7'd0, (i_op == OP_CPC) & c};
                hc = (~i_d & i_r) | (i_r & res) | (res & ~i_d);
                f = i_sreg & KEEP_IT;
                f[5] = hc[3]; f[0] = hc[7];
                f[3] = (i_d[7] & ~i_r[7] & ~res[7]) | (~i_d[7] & i_r[7] & res[7]);
                f = nzs(f, res);
                if (i_op == OP_CPC) f[1] = (res == 8'h00) & i_sreg[1];
                o_sreg = f;
            end
            OP_BRB: begin
                if (i_sreg[b] == !i_w[10]) o_pc = nxt + off;
            end
            OP_ADIW: begin
                f = i_sreg & KEEP_ITH;
                f[3] = ~i_r[7] & wsum[15];
                f[2] = wsum[15];
                f[4] = f[2] ^ f[3];
                f[1] = (wsum == 16'h0000);
                f[0] = i_r[7] & ~wsum[15];
                o_sreg = f;
                o_rf_we = 1'b1; o_rf_wa = lo; o_rf_wd = wsum[7:0];
                o_rf_we1 = 1'b1; o_rf_wd1 = wsum[15:8];
            end
            OP_CBI: o_io_we = 1'b1;
            OP_ASR: begin
                res = {i_d[7], i_d[7:1]};
                f = i_sreg & KEEP_ITH;
                f[0] = i_d[0];
                f[3] = res[7] ^ i_d[0];
                o_sreg = nzs(f, res);
                o_rf_we = 1'b1; o_rf_wd = res;
            end
            OP_COM: begin
                res = ~i_d;
                f = (i_sreg & KEEP_ITH) | 8'h01;
                o_sreg = nzs(f, res);
                o_rf_we = 1'b1; o_rf_wd = res;
            end
            OP_BCLR: o_sreg = i_sreg & ~(8'h01 << i_w[6:4]);
            OP_BSET: o_sreg = i_sreg | (8'h01 << i_w[6:4]);
            OP_BLD: begin
                res = i_d;
                res[b] = i_sreg[6];
                o_rf_we = 1'b1; o_rf_wd = res;
            end
            OP_BST: o_sreg[6] = i_d[b];
            OP_CALL: begin
                o_two = 1'b1;
                o_pc = i_w2;
                o_sp = i_sp - 16'd2;
            end
            default: ;
        endcase
        o_r0 = '{next_pc: o_pc, flags: o_sreg, write_kind: WK_NONE,
                 write_address: 16'h0000, write_data: 8'h00, last: 1'b1};
        if (i_op == OP_CBI) begin
            o_r0.write_kind = WK_IO;
            o_r0.write_address = {11'd1, i_w[7:3]};
            o_r0.write_data = o_io_wd;
        end else if (o_two) begin
            o_r0.write_kind = WK_STACK;
            o_r0.write_address = i_sp;
            o_r0.write_data = ret[7:0];
            o_r0.last = 1'b0;
        end
        o_r1 = '{next_pc: o_pc, flags: o_sreg, write_kind: WK_STACK,
                 write_address: sp1, write_data: ret[15:8], last: 1'b1};
    end
endmodule

// ===== rtl/core/mcu_instruction_execute_subset.sv =====
// Top level of the execute unit: operand read stage, execute/write-back stage,
// output register. Depends on mies_pkg, mies_stream_if, mies_regfile, mies_exec.
//
// Channel | Dir | Payload
// s_in    | in  | instruction_word, second_word
// m_out   | out | next_pc, flags, write_kind, write_address, write_data, last
//
// One instruction per cycle while the output does not stall; CALL occupies the output for two transfers.
// Stage 1 reads the register file (a registered memory read); stage 2
// executes, writes back and loads the output register that offers the result.
// A hazard on a register written by the item in stage 2 is resolved by
// forwarding. Registers live in a memory with valid bits; the I/O
// bank is a 32-byte memory read in stage 1 as well.
// Reset (i_rst_n low, synchronous) empties the pipe, clears SP to the stack
// top, PC and flags to zero. An output stall holds stage 2 and stage 1.
module mcu_instruction_execute_subset (
    input  logic i_clk,
    input  logic i_rst_n,
    mies_stream_if.sink   s_in,
    mies_stream_if.source m_out
);
    import mies_pkg::*;

    // stage 1 (read issued) and stage 2 (data available)
    logic        r_v2, r_half;
    t_in         r_in2;
    t_op         r_op2;
    logic [7:0]  r_sreg;
    logic [15:0] r_pc, r_sp;
    t_out        r_o0, r_o1;
    logic        r_ov;

    logic [4:0]  ra, rb;
    logic [7:0]  da, db, r, io_q, da_fw;
    logic [7:0]  r_ioq_raw;
    logic [31:0] r_io_vld;
    logic        r_io_v;
    logic [7:0]  r_io [32];
    logic [4:0]  r_fa0, r_fa1, r_fio, r_fio2;
    logic [7:0]  r_fd0, r_fd1, r_fiod, r_fiod2;
    logic        r_f0, r_f1, r_fiov, r_fiov2;

    t_op         op_in;
    logic [7:0]  n_sreg;
    logic [15:0] n_pc, n_sp;
    logic        we0, we1, iowe, two;
    logic [4:0]  wa0, wa1;
    logic [7:0]  wd0, wd1, iowd;
    t_out        o0, o1;
    logic        out_free, adv;
    logic        s_we, s1_we;
    logic [4:0]  s_wa, s1_wa;
    logic [7:0]  s_wd, s1_wd;
    logic [15:0] sp1;

    assign op_in = decode(s_in.data.instruction_word);
    // register-pair reads: ADIW uses the pair, ANDI the upper half
    always_comb begin
        ra = s_in.data.instruction_word[8:4];
        rb = {s_in.data.instruction_word[9], s_in.data.instruction_word[3:0]};
        if (op_in == OP_ANDI) ra = {1'b1, s_in.data.instruction_word[7:4]};
        if (op_in == OP_ADIW) begin
            ra = {2'b11, s_in.data.instruction_word[5:4], 1'b0};
            rb = {2'b11, s_in.data.instruction_word[5:4], 1'b1};
        end
    end

    // output free when empty or draining its last transfer
    assign out_free = !r_ov || (m_out.ready && !r_half);
    assign adv      = r_v2 && out_free;
    assign s_in.ready = !r_v2 || adv;

    // forwarding of the write made in the same cycle as the read was issued
    always_comb begin
        logic [4:0] a2, b2;
        a2 = r_in2.instruction_word[8:4];
        b2 = {r_in2.instruction_word[9], r_in2.instruction_word[3:0]};
        if (r_op2 == OP_ANDI) a2 = {1'b1, r_in2.instruction_word[7:4]};
        if (r_op2 == OP_ADIW) begin
            a2 = {2'b11, r_in2.instruction_word[5:4], 1'b0};
            b2 = {2'b11, r_in2.instruction_word[5:4], 1'b1};
        end
        r = db;
        if (r_f0 && r_fa0 == b2) r = r_fd0;
        if (r_f1 && r_fa1 == b2) r = r_fd1;
        da_fw = da;
        if (r_f0 && r_fa0 == a2) da_fw = r_fd0;
        if (r_f1 && r_fa1 == a2) da_fw = r_fd1;
    end
    assign io_q = (r_fiov2 && r_fio2 == r_in2.instruction_word[7:3]) ? r_fiod2
                  : (r_fiov && r_fio == r_in2.instruction_word[7:3]) ? r_fiod
                  : (r_io_v ? r_ioq_raw : 8'h00);

    mies_exec u_exec (
        .i_op(r_op2), .i_w(r_in2.instruction_word), .i_w2(r_in2.second_word),
        .i_d(da_fw), .i_r(r), .i_io(io_q), .i_sreg(r_sreg), .i_pc(r_pc),
        .i_sp(r_sp), .o_sreg(n_sreg), .o_pc(n_pc), .o_sp(n_sp),
        .o_rf_we(we0), .o_rf_wa(wa0), .o_rf_wd(wd0),
        .o_rf_we1(we1), .o_rf_wa1(wa1), .o_rf_wd1(wd1),
        .o_io_we(iowe), .o_io_wd(iowd), .o_r0(o0), .o_r1(o1), .o_two(two)
    );

    // CALL pushes may alias registers (0..31) or I/O (32..63)
    assign sp1 = r_sp - 16'd1;
    always_comb begin
        s_we = we0; s_wa = wa0; s_wd = wd0;
        s1_we = we1; s1_wa = wa1; s1_wd = wd1;
        if (two) begin
            s_we  = (r_sp[15:5] == 11'd0); s_wa = r_sp[4:0]; s_wd = o0.write_data;
            s1_we = (sp1[15:5] == 11'd0);  s1_wa = sp1[4:0]; s1_wd = o1.write_data;
        end
    end
    logic        io_we, io_we2;
    logic [4:0]  io_wa, io_wa2;
    logic [7:0]  io_wd, io_wd2;
    always_comb begin
        io_we = iowe; io_wa = r_in2.instruction_word[7:3]; io_wd = iowd;
        io_we2 = 1'b0; io_wa2 = sp1[4:0]; io_wd2 = o1.write_data;
        if (two) begin
            io_we  = (r_sp[15:5] == 11'd1); io_wa = r_sp[4:0]; io_wd = o0.write_data;
            io_we2 = (sp1[15:5] == 11'd1);
        end
    end

    // a second write in the same cycle also lands on the two-entry forward path
    logic w0, w1;
    assign w0 = adv && s_we;
    assign w1 = adv && s1_we;

    mies_regfile u_rf (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_re(s_in.ready),
        .i_ra(ra), .i_rb(rb), .o_da(da), .o_db(db),
        .i_we0(w0), .i_wa0(s_wa), .i_wd0(s_wd), .i_we1(w1), .i_wa1(s1_wa), .i_wd1(s1_wd)
    );

    logic [4:0] io_ra;
    assign io_ra = s_in.data.instruction_word[7:3];
    always_ff @(posedge i_clk) begin
        if (adv && io_we)  r_io[io_wa]  <= io_wd;
        if (adv && io_we2) r_io[io_wa2] <= io_wd2;
        if (s_in.ready) r_ioq_raw <= r_io[io_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0; r_ov <= 1'b0; r_half <= 1'b0;
            r_sreg <= 8'h00; r_pc <= 16'h0000; r_sp <= StackTop;
            r_f0 <= 1'b0; r_f1 <= 1'b0; r_fiov <= 1'b0; r_fiov2 <= 1'b0;
            r_io_vld <= '0; r_io_v <= 1'b0;
        end else begin
            if (adv) begin
                r_sreg <= n_sreg; r_pc <= n_pc; r_sp <= n_sp;
                if (io_we)  r_io_vld[io_wa]  <= 1'b1;
                if (io_we2) r_io_vld[io_wa2] <= 1'b1;
            end
            if (s_in.ready) begin
                r_v2 <= s_in.valid;
                r_io_v <= r_io_vld[io_ra] || (adv && ((io_we && io_wa == io_ra)
                          || (io_we2 && io_wa2 == io_ra)));
                // writes of this cycle are not seen by the read just issued
                r_f0 <= w0; r_f1 <= w1;
                r_fiov <= adv && io_we; r_fiov2 <= adv && io_we2;
            end
            if (m_out.ready && r_ov) begin
                if (r_half) r_half <= 1'b0;
                else r_ov <= 1'b0;
            end
            if (adv) begin
                r_ov <= 1'b1; r_half <= two;
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (s_in.ready) begin
            r_in2 <= s_in.data;
            r_op2 <= op_in;
            r_fa0 <= s_wa; r_fd0 <= s_wd; r_fa1 <= s1_wa; r_fd1 <= s1_wd;
            r_fio <= io_wa; r_fiod <= io_wd;
            r_fio2 <= io_wa2; r_fiod2 <= io_wd2;
        end
        if (adv) begin
            // r_o1 carries the final transfer of every item
            r_o0 <= o0; r_o1 <= two ? o1 : o0;
        end
    end
    // read data and forward paths are held while stage 2 waits; memory
    // writes only happen on adv
    assign m_out.valid = r_ov;
    assign m_out.data  = r_half ? r_o0 : r_o1;
endmodule

// ===== rtl/core/mies_checker.sv =====
// Port-level checker for the execute unit, bound to the top level.
// Depends on mies_pkg and the defines header.
`include "mcu_instruction_execute_subset_defines.svh"
module mies_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_ov,
    input logic           i_or,
    input mies_pkg::t_out i_od
);
    import mies_pkg::*;
    `MIES_ASSERT_IMP(a_kind, i_clk, i_rst_n, i_ov, i_od.write_kind != 2'd3)
    `MIES_ASSERT_IMP(a_none_last, i_clk, i_rst_n, i_ov && i_od.write_kind == WK_NONE, i_od.last)
    `MIES_ASSERT_NXT(a_pair, i_clk, i_rst_n, i_ov && i_or && !i_od.last,
        i_ov && i_od.last && i_od.write_kind == WK_STACK)
endmodule

bind mcu_instruction_execute_subset mies_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ov(m_out.valid), .i_or(m_out.ready),
    .i_od(m_out.data)
);
